// ----- src/rbfw_pkg.sv -----
package rbfw_pkg;

  localparam int MaxPoints = 32;
  localparam int SlotW = $clog2(MaxPoints);
  localparam int CountW = 6;
  localparam int DenW = 35;
  localparam int RecipW = 32;
  localparam int AccW = 64;
  localparam int NumRegs = 7;
  localparam int AddrW = 5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_WARP = 1'b1;

  typedef enum logic [2:0] {
    REG_AFF_XX = 3'd0,
    REG_AFF_XY = 3'd1,
    REG_AFF_YX = 3'd2,
    REG_AFF_YY = 3'd3,
    REG_OFF_X  = 3'd4,
    REG_OFF_Y  = 3'd5,
    REG_COUNT  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [31:0] rad_sq;
    logic signed [31:0] wt_x;
    logic signed [31:0] wt_y;
  } point_t;

  typedef struct packed {
    logic signed [31:0] aff_xx;
    logic signed [31:0] aff_xy;
    logic signed [31:0] aff_yx;
    logic signed [31:0] aff_yy;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
    logic [CountW-1:0]  count;
  } cfg_t;

  function automatic logic signed [15:0] sat_out(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] q;
    logic signed [AccW-1:0] adj;
    begin
      adj = acc[AccW-1] ? acc + 64'sd65535 : acc;
      q = adj >>> 16;
      if (q > 64'sd32767) sat_out = 16'sh7fff;
      else if (q < -64'sd32768) sat_out = 16'sh8000;
      else sat_out = q[15:0];
    end
  endfunction

endpackage

// ----- src/rbfw_if.sv -----
interface rbfw_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [4:0]  slot;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [15:0] ctrl_x;
  logic [15:0] ctrl_y;
  logic [31:0] ctrl_radius_sq;
  logic signed [31:0] weight_x;
  logic signed [31:0] weight_y;
  modport source (output valid, cmd, slot, pixel_x, pixel_y, ctrl_x, ctrl_y,
                  ctrl_radius_sq, weight_x, weight_y, input ready);
  modport sink (input valid, cmd, slot, pixel_x, pixel_y, ctrl_x, ctrl_y,
                ctrl_radius_sq, weight_x, weight_y, output ready);
endinterface

interface rbfw_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] warped_x;
  logic signed [15:0] warped_y;
  modport source (output valid, warped_x, warped_y, input ready);
  modport sink (input valid, warped_x, warped_y, output ready);
endinterface

// ----- src/rbf_point_warp_eval.sv -----
// Channel | Direction | Payload
// in_     | sink      | cmd, slot, pixel, control point
// out_    | source    | warped_x, warped_y
// cfg_    | APB slave | seven 32-bit registers at 4*i
//
// A load is written at its acceptance edge, and the input is ready again on the next cycle.
// A warp raises out_valid after the affine steps, a pass per table entry and the output step.
// Each table entry takes a memory read, a distance step, a squaring step, a start step, a
// bit-serial reciprocal, a multiply and an accumulate. A finished warp waits in the result
// register while the output is stalled, and loads are still taken during that wait.
// Reset is synchronous and active low; the point table is not cleared.
module rbf_point_warp_eval (
  input  logic                       clk,
  input  logic                       rst_n,
  rbfw_in_if.sink                    in_ch,
  rbfw_out_if.source                 out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [rbfw_pkg::AddrW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_AFF1, S_AFF2, S_RD, S_DIST, S_SQ, S_DEN, S_DIV, S_MUL, S_ACC, S_OUT
  } state_t;

  rbfw_pkg::cfg_t cfg;
  rbfw_pkg::point_t mem [rbfw_pkg::MaxPoints];
  rbfw_pkg::point_t pt_r;

  state_t state_r;
  logic [11:0] px_r, py_r;
  logic [rbfw_pkg::SlotW:0] idx_r, n_r;
  logic signed [rbfw_pkg::AccW-1:0] accx_r, accy_r;
  logic signed [rbfw_pkg::AccW-1:0] mx_r, my_r, ox_r, oy_r;
  logic [rbfw_pkg::DenW-1:0] dxx_r, dyy_r, den_sum;
  logic signed [16:0] dx_r, dy_r;
  logic signed [64:0] tx_r, ty_r;
  logic div_start;
  logic div_done;
  logic [rbfw_pkg::RecipW-1:0] quot;
  logic out_valid_r;
  logic signed [15:0] wx_r, wy_r;
  logic signed [64:0] tx_adj, ty_adj;

  assign cfg_pready = 1'b1;

  rbfw_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .cfg(cfg)
  );

  assign div_start = (state_r == S_DEN);
  assign den_sum = dxx_r + dyy_r + {3'd0, pt_r.rad_sq};

  rbfw_recip u_recip (
    .clk, .rst_n, .start(div_start), .den(den_sum), .done(div_done), .quot(quot)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.warped_x = wx_r;
  assign out_ch.warped_y = wy_r;

  assign tx_adj = tx_r[64] ? tx_r + 65'sd1073741823 : tx_r;
  assign ty_adj = ty_r[64] ? ty_r + 65'sd1073741823 : ty_r;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.cmd == rbfw_pkg::CMD_LOAD) begin
      mem[in_ch.slot] <= '{in_ch.ctrl_x, in_ch.ctrl_y, in_ch.ctrl_radius_sq,
                           in_ch.weight_x, in_ch.weight_y};
    end
    pt_r <= mem[idx_r[rbfw_pkg::SlotW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready && in_ch.cmd == rbfw_pkg::CMD_WARP) begin
            px_r <= in_ch.pixel_x;
            py_r <= in_ch.pixel_y;
            n_r <= (cfg.count > 6'(rbfw_pkg::MaxPoints))
                   ? (rbfw_pkg::SlotW+1)'(rbfw_pkg::MaxPoints)
                   : cfg.count[rbfw_pkg::SlotW:0];
            idx_r <= '0;
            state_r <= S_AFF1;
          end
        end
        S_AFF1: begin
          mx_r <= 64'(cfg.aff_xx * $signed({1'b0, px_r}));
          my_r <= 64'(cfg.aff_yx * $signed({1'b0, px_r}));
          ox_r <= 64'(cfg.aff_xy * $signed({1'b0, py_r}));
          oy_r <= 64'(cfg.aff_yy * $signed({1'b0, py_r}));
          state_r <= S_AFF2;
        end
        S_AFF2: begin
          accx_r <= mx_r + ox_r + 64'(cfg.off_x);
          accy_r <= my_r + oy_r + 64'(cfg.off_y);
          state_r <= (n_r == '0) ? S_OUT : S_RD;
        end
        S_RD: state_r <= S_DIST;
        S_DIST: begin
          dx_r <= $signed({1'b0, px_r, 4'd0}) - $signed({1'b0, pt_r.src_x});
          dy_r <= $signed({1'b0, py_r, 4'd0}) - $signed({1'b0, pt_r.src_y});
          state_r <= S_SQ;
        end
        S_SQ: begin
          dxx_r <= 35'(dx_r * dx_r);
          dyy_r <= 35'(dy_r * dy_r);
          state_r <= S_DEN;
        end
        S_DEN: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state_r <= S_MUL;
        end
        S_MUL: begin
          tx_r <= pt_r.wt_x * $signed({1'b0, quot});
          ty_r <= pt_r.wt_y * $signed({1'b0, quot});
          state_r <= S_ACC;
        end
        S_ACC: begin
          accx_r <= accx_r + 64'(tx_adj >>> 30);
          accy_r <= accy_r + 64'(ty_adj >>> 30);
          idx_r <= idx_r + 1'b1;
          state_r <= (idx_r + 1'b1 == n_r) ? S_OUT : S_RD;
        end
        S_OUT: begin
          if (!out_valid_r) begin
            wx_r <= rbfw_pkg::sat_out(accx_r);
            wy_r <= rbfw_pkg::sat_out(accy_r);
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/rbfw_recip.sv -----
module rbfw_recip (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rbfw_pkg::DenW-1:0]     den,
  output logic                          done,
  output logic [rbfw_pkg::RecipW-1:0]   quot
);
  // Restoring division of 2^38 by den, one quotient bit per cycle.
  localparam int NumW = 39;
  logic [NumW-1:0] rem_r, rem_nxt;
  logic [NumW-1:0] q_r, q_nxt;
  logic [rbfw_pkg::DenW-1:0] den_r;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [NumW-1:0] shifted;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {rem_r[NumW-2:0], (cnt_r == 6'd38)};
    if (start) begin
      rem_nxt = '0;
      q_nxt = '0;
      cnt_nxt = 6'd38;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {4'd0, den_r}) begin
        rem_nxt = shifted - {4'd0, den_r};
        q_nxt = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[NumW-2:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quot = (den_r == '0 || q_r[NumW-1:32] != '0) ? '1 : q_r[31:0];
endmodule

// ----- src/rbfw_cfg.sv -----
module rbfw_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbfw_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output rbfw_pkg::cfg_t             cfg
);
  rbfw_pkg::cfg_t cfg_r;
  logic [2:0] idx;
  logic wr;

  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.aff_xx <= 32'sd65536;
      cfg_r.aff_xy <= '0;
      cfg_r.aff_yx <= '0;
      cfg_r.aff_yy <= 32'sd65536;
      cfg_r.off_x <= '0;
      cfg_r.off_y <= '0;
      cfg_r.count <= '0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (idx)
        rbfw_pkg::REG_AFF_XX: cfg_r.aff_xx <= pwdata;
        rbfw_pkg::REG_AFF_XY: cfg_r.aff_xy <= pwdata;
        rbfw_pkg::REG_AFF_YX: cfg_r.aff_yx <= pwdata;
        rbfw_pkg::REG_AFF_YY: cfg_r.aff_yy <= pwdata;
        rbfw_pkg::REG_OFF_X:  cfg_r.off_x <= pwdata;
        rbfw_pkg::REG_OFF_Y:  cfg_r.off_y <= pwdata;
        rbfw_pkg::REG_COUNT:  cfg_r.count <= pwdata[rbfw_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rbfw_pkg::REG_AFF_XX: prdata = cfg_r.aff_xx;
      rbfw_pkg::REG_AFF_XY: prdata = cfg_r.aff_xy;
      rbfw_pkg::REG_AFF_YX: prdata = cfg_r.aff_yx;
      rbfw_pkg::REG_AFF_YY: prdata = cfg_r.aff_yy;
      rbfw_pkg::REG_OFF_X:  prdata = cfg_r.off_x;
      rbfw_pkg::REG_OFF_Y:  prdata = cfg_r.off_y;
      rbfw_pkg::REG_COUNT:  prdata = {26'd0, cfg_r.count};
      default:              prdata = '0;
    endcase
  end

  assign cfg = cfg_r;
endmodule

// ----- src/rbfw_checker.sv -----
module rbfw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_cmd,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_x
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x))
    else $error("result dropped while stalled");
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == rbfw_pkg::CMD_LOAD |=> in_ready)
    else $error("load did not leave block ready");
  a_warp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == rbfw_pkg::CMD_WARP |=> !in_ready)
    else $error("warp did not occupy block");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind rbf_point_warp_eval rbfw_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_cmd(in_ch.cmd), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_x(out_ch.warped_x)
);

// ----- sim/rbf_point_warp_eval_tb.sv -----
`timescale 1ns / 100ps

module rbf_point_warp_eval_tb;

  typedef struct {
    logic        cmd;
    logic [4:0]  slot;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] ctrl_x;
    logic [15:0] ctrl_y;
    logic [31:0] ctrl_radius_sq;
    logic signed [31:0] weight_x;
    logic signed [31:0] weight_y;
  } warp_cmd_t;

  typedef struct {
    logic signed [15:0] wx;
    logic signed [15:0] wy;
  } warped_pos_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [rbfw_pkg::AddrW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  rbfw_in_if in_ch ();
  rbfw_out_if out_ch ();

  rbf_point_warp_eval dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  logic signed [31:0] m_aff_xx, m_aff_xy, m_aff_yx, m_aff_yy, m_off_x, m_off_y;
  logic [rbfw_pkg::CountW-1:0] m_count;
  logic [15:0] tab_src_x [rbfw_pkg::MaxPoints];
  logic [15:0] tab_src_y [rbfw_pkg::MaxPoints];
  logic [31:0] tab_rad_sq [rbfw_pkg::MaxPoints];
  logic signed [31:0] tab_wt_x [rbfw_pkg::MaxPoints];
  logic signed [31:0] tab_wt_y [rbfw_pkg::MaxPoints];

  warped_pos_t pending_warps [$];
  int mismatches = 0;
  int failures = 0;
  bit no_idle = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #100000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [15:0] sat_to_pixel(longint acc);
    longint q;
    q = acc / 65536;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic longint basis_recip(longint unsigned d);
    longint unsigned q;
    if (d == 0) return 64'hFFFFFFFF;
    q = (64'd1 << 38) / d;
    return (q > 64'hFFFFFFFF) ? 64'hFFFFFFFF : longint'(q);
  endfunction

  function automatic warped_pos_t compute_warp(warp_cmd_t t);
    warped_pos_t r;
    longint ax, ay, px, py, dx, dy, g;
    longint unsigned d;
    int n;
    px = t.pixel_x;
    py = t.pixel_y;
    ax = longint'(m_aff_xx) * px + longint'(m_aff_xy) * py + longint'(m_off_x);
    ay = longint'(m_aff_yx) * px + longint'(m_aff_yy) * py + longint'(m_off_y);
    n = (m_count > rbfw_pkg::MaxPoints) ? rbfw_pkg::MaxPoints : m_count;
    for (int i = 0; i < n; i++) begin
      dx = px * 16 - longint'(tab_src_x[i]);
      dy = py * 16 - longint'(tab_src_y[i]);
      d = longint'(dx * dx) + longint'(dy * dy) + longint'(tab_rad_sq[i]);
      g = basis_recip(d);
      ax += (longint'(tab_wt_x[i]) * g) / (64'sd1 <<< 30);
      ay += (longint'(tab_wt_y[i]) * g) / (64'sd1 <<< 30);
    end
    r.wx = sat_to_pixel(ax);
    r.wy = sat_to_pixel(ay);
    return r;
  endfunction

  task automatic apply_transaction(warp_cmd_t t);
    if (t.cmd == rbfw_pkg::CMD_LOAD) begin
      tab_src_x[t.slot] = t.ctrl_x;
      tab_src_y[t.slot] = t.ctrl_y;
      tab_rad_sq[t.slot] = t.ctrl_radius_sq;
      tab_wt_x[t.slot] = t.weight_x;
      tab_wt_y[t.slot] = t.weight_y;
    end else begin
      pending_warps.push_back(compute_warp(t));
    end
  endtask

  task automatic send_item(warp_cmd_t t);
    while (!no_idle && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= t.cmd;
    in_ch.slot <= t.slot;
    in_ch.pixel_x <= t.pixel_x;
    in_ch.pixel_y <= t.pixel_y;
    in_ch.ctrl_x <= t.ctrl_x;
    in_ch.ctrl_y <= t.ctrl_y;
    in_ch.ctrl_radius_sq <= t.ctrl_radius_sq;
    in_ch.weight_x <= t.weight_x;
    in_ch.weight_y <= t.weight_y;
    do @(posedge clk); while (!in_ch.ready);
    apply_transaction(t);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_warps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(rbfw_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      rbfw_pkg::REG_AFF_XX: m_aff_xx = value;
      rbfw_pkg::REG_AFF_XY: m_aff_xy = value;
      rbfw_pkg::REG_AFF_YX: m_aff_yx = value;
      rbfw_pkg::REG_AFF_YY: m_aff_yy = value;
      rbfw_pkg::REG_OFF_X:  m_off_x = value;
      rbfw_pkg::REG_OFF_Y:  m_off_y = value;
      rbfw_pkg::REG_COUNT:  m_count = value[rbfw_pkg::CountW-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  function automatic warp_cmd_t make_load(int slot);
    warp_cmd_t t;
    t.cmd = rbfw_pkg::CMD_LOAD;
    t.slot = 5'(slot);
    t.pixel_x = 12'($urandom);
    t.pixel_y = 12'($urandom);
    t.ctrl_x = 16'($urandom);
    t.ctrl_y = 16'($urandom);
    t.ctrl_radius_sq = $urandom_range(1) ? $urandom : $urandom_range(0, 65535);
    t.weight_x = rand_q16();
    t.weight_y = rand_q16();
    return t;
  endfunction

  function automatic warp_cmd_t make_warp();
    warp_cmd_t t;
    int s;
    t = make_load(0);
    t.cmd = rbfw_pkg::CMD_WARP;
    t.slot = 5'($urandom);
    if ($urandom_range(9) == 0) begin
      s = $urandom_range(rbfw_pkg::MaxPoints - 1);
      t.pixel_x = tab_src_x[s][15:4];
      t.pixel_y = tab_src_y[s][15:4];
    end
    return t;
  endfunction

  task automatic random_config();
    write_reg(rbfw_pkg::REG_AFF_XX, $urandom_range(3) == 0 ? rand_q16() : 32'h00010000);
    write_reg(rbfw_pkg::REG_AFF_XY, rand_q16());
    write_reg(rbfw_pkg::REG_AFF_YX, rand_q16());
    write_reg(rbfw_pkg::REG_AFF_YY, $urandom_range(3) == 0 ? rand_q16() : 32'h00010000);
    write_reg(rbfw_pkg::REG_OFF_X, $urandom_range(1) ? rand_q16() : $urandom);
    write_reg(rbfw_pkg::REG_OFF_Y, $urandom_range(1) ? rand_q16() : $urandom);
    case ($urandom_range(9))
      0: write_reg(rbfw_pkg::REG_COUNT, $urandom_range(32, 63));
      1: write_reg(rbfw_pkg::REG_COUNT, $urandom_range(5, 16));
      default: write_reg(rbfw_pkg::REG_COUNT, $urandom_range(0, 4));
    endcase
  endtask

  task automatic test_directed();
    warp_cmd_t t;
    t = make_load(0);
    t.ctrl_x = 16'h0000;
    t.ctrl_y = 16'h0000;
    t.ctrl_radius_sq = 32'h0;
    t.weight_x = 32'h7FFFFFFF;
    t.weight_y = 32'h80000000;
    send_item(t);
    t = make_load(1);
    t.ctrl_x = 16'hFFFF;
    t.ctrl_y = 16'hFFFF;
    t.ctrl_radius_sq = 32'hFFFFFFFF;
    t.weight_x = 32'h80000000;
    t.weight_y = 32'h7FFFFFFF;
    send_item(t);
    wait_idle();
    write_reg(rbfw_pkg::REG_AFF_XX, 32'h7FFFFFFF);
    write_reg(rbfw_pkg::REG_AFF_XY, 32'h7FFFFFFF);
    write_reg(rbfw_pkg::REG_AFF_YX, 32'h80000000);
    write_reg(rbfw_pkg::REG_AFF_YY, 32'h80000000);
    write_reg(rbfw_pkg::REG_OFF_X, 32'h7FFFFFFF);
    write_reg(rbfw_pkg::REG_OFF_Y, 32'h80000000);
    write_reg(rbfw_pkg::REG_COUNT, 32'd0);
    t.cmd = rbfw_pkg::CMD_WARP;
    t.pixel_x = 12'hFFF;
    t.pixel_y = 12'hFFF;
    send_item(t);
    t.pixel_x = 12'h000;
    t.pixel_y = 12'h000;
    send_item(t);
    t.pixel_x = 12'hFFF;
    send_item(t);
    wait_idle();
    write_reg(rbfw_pkg::REG_AFF_XX, 32'h0);
    write_reg(rbfw_pkg::REG_AFF_YY, 32'h0);
    write_reg(rbfw_pkg::REG_AFF_XY, 32'h0);
    write_reg(rbfw_pkg::REG_AFF_YX, 32'h0);
    write_reg(rbfw_pkg::REG_OFF_X, 32'h0);
    write_reg(rbfw_pkg::REG_OFF_Y, 32'h0);
    write_reg(rbfw_pkg::REG_COUNT, 32'd1);
    t.pixel_x = 12'h000;
    t.pixel_y = 12'h000;
    send_item(t);
    t.pixel_x = 12'h001;
    send_item(t);
    wait_idle();
    write_reg(rbfw_pkg::REG_COUNT, 32'd2);
    t.pixel_x = 12'hFFF;
    t.pixel_y = 12'hFFF;
    send_item(t);
    t.pixel_x = 12'h800;
    t.pixel_y = 12'h7FF;
    send_item(t);
    wait_idle();
  endtask

  task automatic test_fill_table();
    for (int s = 0; s < rbfw_pkg::MaxPoints; s++) send_item(make_load(s));
    wait_idle();
    write_reg(rbfw_pkg::REG_AFF_XX, 32'h00010000);
    write_reg(rbfw_pkg::REG_AFF_YY, 32'h00010000);
    write_reg(rbfw_pkg::REG_COUNT, 32'd63);
    send_item(make_warp());
    send_item(make_warp());
    wait_idle();
  endtask

  task automatic run_phase(int items);
    random_config();
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(99) < 30)
        send_item(make_load($urandom_range(rbfw_pkg::MaxPoints - 1)));
      else
        send_item(make_warp());
    end
    wait_idle();
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) run_phase(107);
  endtask

  task automatic test_back_to_back();
    no_idle = 1;
    run_phase(200);
    no_idle = 0;
  endtask

  always @(posedge clk) begin
    warped_pos_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_warps.size() == 0) begin
        failures++;
        if (mismatches++ < 10)
          $display("unexpected result x=%0d y=%0d", out_ch.warped_x, out_ch.warped_y);
      end else begin
        e = pending_warps.pop_front();
        if (out_ch.warped_x !== e.wx || out_ch.warped_y !== e.wy) begin
          failures++;
          if (mismatches++ < 10)
            $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     e.wx, e.wy, out_ch.warped_x, out_ch.warped_y);
        end
      end
    end
    out_ch.ready <= no_idle || ($urandom_range(99) >= 7);
  end

  initial begin
    m_aff_xx = 32'h00010000;
    m_aff_xy = 0;
    m_aff_yx = 0;
    m_aff_yy = 32'h00010000;
    m_off_x = 0;
    m_off_y = 0;
    m_count = 0;
    rst_n <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= rbfw_pkg::CMD_LOAD;
    in_ch.slot <= '0;
    in_ch.pixel_x <= '0;
    in_ch.pixel_y <= '0;
    in_ch.ctrl_x <= '0;
    in_ch.ctrl_y <= '0;
    in_ch.ctrl_radius_sq <= '0;
    in_ch.weight_x <= '0;
    in_ch.weight_y <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_table();
    test_random();
    test_back_to_back();
    test_random();
    wait_idle();
    repeat (50) @(posedge clk);
    failures += pending_warps.size();
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rbfw_pkg.sv
src/rbfw_if.sv
src/rbfw_recip.sv
src/rbfw_cfg.sv
src/rbf_point_warp_eval.sv
src/rbfw_checker.sv
sim/rbf_point_warp_eval_tb.sv
